// File: hw/rtl/psf_pkg.sv
// Shared types, constants and edge mask tables for the planar span fill writer.
// Used by psf_front, psf_queue, psf_back and planar_span_fill_writer.
`default_nettype none

package psf_pkg;

  localparam int ADDR_W  = 16;
  localparam int LINE_W  = 10;
  localparam int X_W     = 12;
  localparam int Y_W     = 9;
  localparam int COLOR_W = 8;
  localparam int MASK_W  = 4;
  localparam int RUN_W   = 10;
  localparam int PROD_W  = Y_W + LINE_W;
  localparam int CFG_INDEX_W = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_OFFSET = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_BYTES    = 2'd1;

  localparam logic [ADDR_W-1:0] BUFFER_OFFSET_RESET = 16'd0;
  localparam logic [LINE_W-1:0] LINE_BYTES_RESET    = 10'd80;

  localparam logic CMD_PLOT = 1'b0;
  localparam logic CMD_SPAN = 1'b1;

  localparam logic [MASK_W-1:0] FULL_MASK = 4'hF;

  localparam logic [MASK_W-1:0] SINGLE_PLANE [4] = '{4'd1, 4'd2, 4'd4, 4'd8};
  localparam logic [MASK_W-1:0] START_EDGE   [4] = '{4'd15, 4'd14, 4'd12, 4'd8};
  localparam logic [MASK_W-1:0] END_EDGE     [4] = '{4'd1, 4'd3, 4'd7, 4'd15};

  typedef struct packed {
    logic               single;
    logic [ADDR_W-1:0]  base;
    logic [MASK_W-1:0]  lmask;
    logic [MASK_W-1:0]  rmask;
    logic [RUN_W-1:0]   mid;
    logic [COLOR_W-1:0] color;
  } psf_job_t;

  typedef struct packed {
    logic push;
    logic pop;
  } psf_qctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } psf_qstat_t;

  typedef enum logic [1:0] {
    ST_FIRST,
    ST_MID,
    ST_RIGHT
  } psf_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/psf_front.sv
// Front end: configuration registers, item intake, row multiply and span classification.
// Depends on psf_pkg; feeds classified jobs into psf_queue.
`default_nettype none

module psf_front
  import psf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic                   command,
  input  wire logic [X_W-1:0]         pos_x,
  input  wire logic [Y_W-1:0]         pos_y,
  input  wire logic [X_W-1:0]         span_width,
  input  wire logic [COLOR_W-1:0]     fill_color,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]      cfg_data,
  input  wire logic                   q_full,
  output logic                        q_push,
  output psf_job_t                    job
);

  logic [ADDR_W-1:0]  buffer_offset;
  logic [LINE_W-1:0]  line_bytes;

  logic               s1_valid;
  logic               s1_cmd;
  logic [X_W-1:0]     s1_x;
  logic [X_W-1:0]     s1_w;
  logic [COLOR_W-1:0] s1_color;
  logic [PROD_W-1:0]  s1_prod;
  logic [ADDR_W-1:0]  s1_partial;

  logic               s1_ready;
  logic               drop;
  logic [X_W:0]       end_pos;
  logic [X_W-3:0]     first_byte;
  logic [X_W-2:0]     last_byte;
  logic [X_W-2:0]     mid_wide;
  logic [MASK_W-1:0]  lmask;
  logic [MASK_W-1:0]  rmask;

  assign cfg_ready = 1'b1;

  assign drop     = (s1_cmd == CMD_SPAN) && (s1_w == '0);
  assign s1_ready = !s1_valid || drop || !q_full;
  assign full     = !s1_ready;
  assign q_push   = s1_valid && !drop && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      buffer_offset <= BUFFER_OFFSET_RESET;
      line_bytes    <= LINE_BYTES_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_BUFFER_OFFSET: buffer_offset <= cfg_data;
          CFG_LINE_BYTES:    line_bytes    <= cfg_data[LINE_W-1:0];
          default: ;
        endcase
      end
      if (s1_ready) begin
        s1_valid <= push;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && push) begin
      s1_cmd     <= command;
      s1_x       <= pos_x;
      s1_w       <= span_width;
      s1_color   <= fill_color;
      s1_prod    <= PROD_W'(pos_y) * PROD_W'(line_bytes);
      s1_partial <= buffer_offset + ADDR_W'(pos_x[X_W-1:2]);
    end
  end

  always_comb begin
    end_pos    = {1'b0, s1_x} + {1'b0, s1_w} - (X_W+1)'(1);
    first_byte = s1_x[X_W-1:2];
    last_byte  = end_pos[X_W:2];
    mid_wide   = last_byte - {1'b0, first_byte} - (X_W-1)'(1);
    lmask      = START_EDGE[s1_x[1:0]];
    rmask      = END_EDGE[end_pos[1:0]];

    job.base  = s1_partial + s1_prod[ADDR_W-1:0];
    job.color = s1_color;
    job.rmask = rmask;
    job.mid   = mid_wide[RUN_W-1:0];
    if (s1_cmd == CMD_PLOT) begin
      job.single = 1'b1;
      job.lmask  = SINGLE_PLANE[s1_x[1:0]];
    end else if (last_byte == {1'b0, first_byte}) begin
      job.single = 1'b1;
      job.lmask  = lmask & rmask;
    end else begin
      job.single = 1'b0;
      job.lmask  = lmask;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/psf_queue.sv
// Short job queue between the front end and the write sequencer.
// Depends on psf_pkg for the job type and depth.
`default_nettype none

module psf_queue
  import psf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire psf_qctl_t ctl,
  output psf_qstat_t  stat,
  input  wire psf_job_t  wr_job,
  output psf_job_t    rd_job
);

  psf_job_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                do_push;
  logic                do_pop;

  assign stat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = ctl.push && !stat.full;
  assign do_pop     = ctl.pop && !stat.empty;
  assign rd_job     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/psf_back.sv
// Write sequencer: expands each job into edge and middle-run writes into the result register.
// Depends on psf_pkg; takes jobs from psf_queue.
`default_nettype none

module psf_back
  import psf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_empty,
  input  wire psf_job_t            job,
  output logic                     q_pop,
  output logic                     empty,
  input  wire logic                pop,
  output logic [ADDR_W-1:0]        byte_address,
  output logic [MASK_W-1:0]        plane_mask,
  output logic [RUN_W-1:0]         run_length,
  output logic [COLOR_W-1:0]       write_color,
  output logic                     last
);

  psf_state_t         state;
  psf_state_t         state_next;
  logic               out_valid;
  logic               load;
  logic               emit;
  logic [ADDR_W-1:0]  addr_next;
  logic [MASK_W-1:0]  mask_next;
  logic [RUN_W-1:0]   run_next;
  logic               last_next;

  assign empty = !out_valid;
  assign load  = !out_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FIRST;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_address <= addr_next;
      plane_mask   <= mask_next;
      run_length   <= run_next;
      write_color  <= job.color;
      last         <= last_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    emit       = 1'b0;
    addr_next  = job.base;
    mask_next  = job.lmask;
    run_next   = RUN_W'(1);
    last_next  = 1'b0;
    unique case (state)
      ST_FIRST: begin
        if (!q_empty && load) begin
          emit = 1'b1;
          if (job.single) begin
            last_next = 1'b1;
            q_pop     = 1'b1;
          end else if (job.mid != '0) begin
            state_next = ST_MID;
          end else begin
            state_next = ST_RIGHT;
          end
        end
      end
      ST_MID: begin
        addr_next = job.base + ADDR_W'(1);
        mask_next = FULL_MASK;
        run_next  = job.mid;
        if (load) begin
          emit       = 1'b1;
          state_next = ST_RIGHT;
        end
      end
      ST_RIGHT: begin
        addr_next = job.base + ADDR_W'(1) + ADDR_W'(job.mid);
        mask_next = job.rmask;
        last_next = 1'b1;
        if (load) begin
          emit       = 1'b1;
          q_pop      = 1'b1;
          state_next = ST_FIRST;
        end
      end
      default: state_next = ST_FIRST;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/planar_span_fill_writer.sv
// Top level of the planar span fill writer: front end, job queue and write sequencer.
// Depends on psf_pkg, psf_front, psf_queue and psf_back.
`default_nettype none

// Converts pixel plots and horizontal span fills into masked writes for four-plane
// video memory. Each write gives a 16-bit byte address (buffer_offset + pos_y *
// line_bytes + pos_x / 4, wrapping), a plane mask, a run length in bytes, the colour
// and a last flag on the final write of the item. A plot or a span inside one byte
// gives one write; a wider span gives a left edge, an optional full-mask middle run
// and a right edge. A span of width zero gives nothing. Items enter one a cycle,
// unless the queue is full, into a one-stage front end (row multiply and
// classification) that feeds a four-entry job queue; the write sequencer then
// issues one write per cycle while the result ports are empty or popped. The first
// write of an item passes the front-end register, a queue slot and the result
// register. Configuration is written through the cfg port, which is always ready;
// writes to indexes past the two registers are ignored.

module planar_span_fill_writer
  import psf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic                   command,
  input  wire logic [X_W-1:0]         pos_x,
  input  wire logic [Y_W-1:0]         pos_y,
  input  wire logic [X_W-1:0]         span_width,
  input  wire logic [COLOR_W-1:0]     fill_color,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [ADDR_W-1:0]           byte_address,
  output logic [MASK_W-1:0]           plane_mask,
  output logic [RUN_W-1:0]            run_length,
  output logic [COLOR_W-1:0]          write_color,
  output logic                        last,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]      cfg_data
);

  psf_job_t   front_job;
  psf_job_t   head_job;
  psf_qctl_t  qctl;
  psf_qstat_t qstat;

  psf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .command    (command),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .span_width (span_width),
    .fill_color (fill_color),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (qstat.full),
    .q_push     (qctl.push),
    .job        (front_job)
  );

  psf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .ctl    (qctl),
    .stat   (qstat),
    .wr_job (front_job),
    .rd_job (head_job)
  );

  psf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (qstat.empty),
    .job          (head_job),
    .q_pop        (qctl.pop),
    .empty        (empty),
    .pop          (pop),
    .byte_address (byte_address),
    .plane_mask   (plane_mask),
    .run_length   (run_length),
    .write_color  (write_color),
    .last         (last)
  );

endmodule

`default_nettype wire
